[rtl/vr_pkg.sv]
`default_nettype none

package vr_pkg;

  localparam int LANES = 3;

  // Direction length: 32-bit sum of squares scaled up by 2^28.
  localparam int SQ1_IW = 60;
  localparam int SQ1_OW = SQ1_IW / 2;
  // Unit direction divider.
  localparam int NUM_SH = 29;
  localparam int DIV_NW = 46;
  localparam int DIV_DW = SQ1_OW + 1;
  localparam int DIV_QW = 15;
  // Discriminant root; a positive discriminant stays below 2^53.
  localparam int SQ2_IW = 56;
  localparam int SQ2_OW = SQ2_IW / 2;

  localparam int Q_SH   = 14;
  localparam int OUT_SH = 28;
  localparam int ROOT_SH = 7;
  localparam int DT_W   = 20;
  localparam int OM_W   = 40;
  localparam int EO_W   = 56;
  localparam int T_W    = 44;
  localparam int ET_W   = 60;
  localparam int DISC_W = 62;
  localparam int ND_W   = 36;
  localparam int NR_W   = 45;
  localparam int TG_W   = 38;
  localparam int AC_W   = 57;

  localparam logic [63:0] ONE_Q28 = 64'd1 << 28;
  localparam logic [63:0] ONE_Q42 = 64'd1 << 42;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [15:0] eta_ratio;
  } vr_ray_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               did_refract;
  } vr_res_t;

  // Travels alongside the length and divider pipelines.
  typedef struct packed {
    logic [LANES-1:0][15:0] d;
    logic [LANES-1:0][15:0] n;
    logic [15:0]            eta;
    logic                   zero;
  } vr_side1_t;

  // Travels alongside the cosine, discriminant and root stages.
  typedef struct packed {
    logic [LANES-1:0][15:0] u;
    logic [LANES-1:0][15:0] n;
    logic [15:0]            eta;
    logic [DT_W-1:0]        dt;
    logic                   ok;
  } vr_side2_t;

  // Arithmetic shift right with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int sh);
    logic signed [63:0] h;
    h = 64'sd1 <<< (sh - 1);
    if (v < 0) begin
      return (v + h - 64'sd1) >>> sh;
    end
    return (v + h) >>> sh;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'h7fff;
    end
    if (v < -64'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/vr_sqrt.sv]
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module vr_sqrt import vr_pkg::*; #(
  parameter int IW     = SQ1_IW,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [IW-1:0]     x,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [IW/2-1:0]        root,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int OW = IW / 2;
  localparam int RW = OW + 2;

  logic [OW-1:0]     vq;
  logic [IW-1:0]     xq [0:OW-2];
  logic [RW-1:0]     rq [0:OW-2];
  logic [OW-1:0]     tq [0:OW-1];
  logic [SIDE_W-1:0] sq [0:OW-1];

  logic [IW-1:0]     xi    [0:OW-1];
  logic [RW-1:0]     ri    [0:OW-1];
  logic [OW-1:0]     ti    [0:OW-1];
  logic [SIDE_W-1:0] si    [0:OW-1];
  logic [RW-1:0]     rsh   [0:OW-1];
  logic [RW-1:0]     trial [0:OW-1];
  logic [RW-1:0]     nrem  [0:OW-1];
  logic [OW-1:0]     nroot [0:OW-1];

  always_comb begin
    xi[0] = x;
    ri[0] = '0;
    ti[0] = '0;
    si[0] = side_in;
    for (int k = 1; k < OW; k++) begin
      xi[k] = xq[k-1];
      ri[k] = rq[k-1];
      ti[k] = tq[k-1];
      si[k] = sq[k-1];
    end
    for (int k = 0; k < OW; k++) begin
      rsh[k]   = {ri[k][RW-3:0], xi[k][IW-1-2*k -: 2]};
      trial[k] = {ti[k], 2'b01};
      if (rsh[k] >= trial[k]) begin
        nrem[k]  = rsh[k] - trial[k];
        nroot[k] = {ti[k][OW-2:0], 1'b1};
      end else begin
        nrem[k]  = rsh[k];
        nroot[k] = {ti[k][OW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else begin
      vq <= {vq[OW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < OW - 1; k++) begin
      xq[k] <= xi[k];
      rq[k] <= nrem[k];
    end
    for (int k = 0; k < OW; k++) begin
      tq[k] <= nroot[k];
      sq[k] <= si[k];
    end
  end

  assign out_valid = vq[OW-1];
  assign root      = tq[OW-1];
  assign side_out  = sq[OW-1];

endmodule

`default_nettype wire

[rtl/vr_div.sv]
`default_nettype none

// Pipelined restoring divider for three numerators over one divisor.
// The quotient must fit in QW bits; one quotient bit per stage.
module vr_div import vr_pkg::*; #(
  parameter int NW     = DIV_NW,
  parameter int DW     = DIV_DW,
  parameter int QW     = DIV_QW,
  parameter int SIDE_W = 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [LANES-1:0][NW-1:0] num,
  input  wire logic [DW-1:0]            den,
  input  wire logic [SIDE_W-1:0]        side_in,
  output logic                          out_valid,
  output logic [LANES-1:0][QW-1:0]      quo,
  output logic [SIDE_W-1:0]             side_out
);

  logic [QW-1:0]                vq;
  logic [LANES-1:0][NW-1:0]     nq [0:QW-2];
  logic [DW-1:0]                dq [0:QW-2];
  logic [LANES-1:0][QW-1:0]     qq [0:QW-1];
  logic [SIDE_W-1:0]            sq [0:QW-1];

  logic [LANES-1:0][NW-1:0]     ni  [0:QW-1];
  logic [DW-1:0]                di  [0:QW-1];
  logic [LANES-1:0][QW-1:0]     qi  [0:QW-1];
  logic [SIDE_W-1:0]            si  [0:QW-1];
  logic [NW-1:0]                ds  [0:QW-1];
  logic [LANES-1:0][NW-1:0]     nn  [0:QW-1];
  logic [LANES-1:0][QW-1:0]     nqt [0:QW-1];

  always_comb begin
    ni[0] = num;
    di[0] = den;
    qi[0] = '0;
    si[0] = side_in;
    for (int k = 1; k < QW; k++) begin
      ni[k] = nq[k-1];
      di[k] = dq[k-1];
      qi[k] = qq[k-1];
      si[k] = sq[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      ds[k] = NW'(di[k]) << (QW - 1 - k);
      for (int l = 0; l < LANES; l++) begin
        if (ni[k][l] >= ds[k]) begin
          nn[k][l]  = ni[k][l] - ds[k];
          nqt[k][l] = {qi[k][l][QW-2:0], 1'b1};
        end else begin
          nn[k][l]  = ni[k][l];
          nqt[k][l] = {qi[k][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else begin
      vq <= {vq[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW - 1; k++) begin
      nq[k] <= nn[k];
      dq[k] <= di[k];
    end
    for (int k = 0; k < QW; k++) begin
      qq[k] <= nqt[k];
      sq[k] <= si[k];
    end
  end

  assign out_valid = vq[QW-1];
  assign quo       = qq[QW-1];
  assign side_out  = sq[QW-1];

endmodule

`default_nettype wire

[rtl/vector_refraction.sv]
`default_nettype none

// Refracts one ray per clock cycle. The delay from an accepted start to its
// done strobe is set mostly by the two square root pipelines (30 stages for
// the direction length, 28 for the discriminant root, one root bit each)
// and the 15-stage divider that normalizes the direction. busy is always
// low, and each result is shown for exactly one cycle with done high; there
// is no way to hold it off.
module vector_refraction import vr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire vr_ray_t ray,
  output logic         done,
  output vr_res_t      result
);

  localparam int SIDE1_W = $bits(vr_side1_t);
  localparam int SIDE2_W = $bits(vr_side2_t);
  localparam int LATENCY = 2 + SQ1_OW + 1 + DIV_QW + 9 + SQ2_OW + 5;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic [LANES-1:0][15:0] din, nin;
  assign din = {ray.dir_z, ray.dir_y, ray.dir_x};
  assign nin = {ray.norm_z, ray.norm_y, ray.norm_x};

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15, v16;
  logic v3a, v4a, v13a;

  // Squares of the direction.
  logic [LANES-1:0][31:0] sq1, sqc;
  vr_side1_t              c1;
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sqc[i] = 32'(signed'(din[i])) * 32'(signed'(din[i]));
    end
  end

  // Length squared, scaled for the root.
  logic [31:0]        l2sum;
  logic [SQ1_IW-1:0]  x2;
  vr_side1_t          c2, c2n;
  always_comb begin
    l2sum    = sq1[0] + sq1[1] + sq1[2];
    c2n      = c1;
    c2n.zero = (l2sum == '0);
  end

  logic [SQ1_OW-1:0] s3;
  vr_side1_t         c3a;
  vr_sqrt #(.IW(SQ1_IW), .SIDE_W(SIDE1_W)) u_len_sqrt (
    .clk(clk), .rst(rst), .in_valid(v2), .x(x2), .side_in(c2),
    .out_valid(v3a), .root(s3), .side_out(c3a)
  );

  // Divider operands: the quotient is the unit direction magnitude.
  logic [LANES-1:0][DIV_NW-1:0] num3, num3n;
  logic [DIV_DW-1:0]            den3, den3n;
  vr_side1_t                    c3;
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (c3a.d[i][15]) begin
        num3n[i] = (DIV_NW'(16'(-c3a.d[i])) << NUM_SH) + DIV_NW'(s3);
      end else begin
        num3n[i] = (DIV_NW'(c3a.d[i]) << NUM_SH) + DIV_NW'(s3);
      end
    end
    // A zero direction divides nothing; keep the divisor nonzero.
    den3n = c3a.zero ? DIV_DW'(1) : {s3, 1'b0};
  end

  logic [LANES-1:0][DIV_QW-1:0] q4;
  vr_side1_t                    c4a;
  vr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW), .SIDE_W(SIDE1_W)) u_div (
    .clk(clk), .rst(rst), .in_valid(v3), .num(num3), .den(den3), .side_in(c3),
    .out_valid(v4a), .quo(q4), .side_out(c4a)
  );

  // Signed unit direction and its products with the normal.
  logic [LANES-1:0][15:0] u4c;
  logic [LANES-1:0][31:0] p4, p4c;
  vr_side2_t              c4, c4n;
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      u4c[i] = c4a.d[i][15] ? 16'(-16'(q4[i])) : 16'(q4[i]);
      p4c[i] = 32'(signed'(u4c[i])) * 32'(signed'(c4a.n[i]));
    end
    c4n.u   = u4c;
    c4n.n   = c4a.n;
    c4n.eta = c4a.eta;
    c4n.dt  = '0;
    c4n.ok  = !c4a.zero;
  end

  logic signed [33:0]       dot5;
  logic signed [OM_W-1:0]   dsq7, om8;
  logic signed [EO_W-1:0]   eo9;
  logic signed [T_W-1:0]    t10;
  logic signed [ET_W-1:0]   et11;
  logic signed [DISC_W-1:0] discc;
  logic [SQ2_IW-1:0]        d12;
  vr_side2_t                c5, c6, c7, c8, c9, c10, c11, c12, c6n, c12n;

  always_comb begin
    c6n    = c5;
    c6n.dt = DT_W'(rnd_shr(64'(dot5), Q_SH));
    discc  = DISC_W'(ONE_Q42) - DISC_W'(et11);
    c12n    = c11;
    c12n.ok = c11.ok && !discc[DISC_W-1] && (discc != '0);
  end

  logic [SQ2_OW-1:0] root13;
  vr_side2_t         c13a, c13, c14, c15, c16;
  vr_sqrt #(.IW(SQ2_IW), .SIDE_W(SIDE2_W)) u_disc_sqrt (
    .clk(clk), .rst(rst), .in_valid(v12), .x(d12), .side_in(c12),
    .out_valid(v13a), .root(root13), .side_out(c13a)
  );

  logic signed [LANES-1:0][ND_W-1:0] nd13;
  logic signed [LANES-1:0][NR_W-1:0] nr13;
  logic signed [LANES-1:0][TG_W-1:0] tang14;
  logic signed [LANES-1:0][AC_W-1:0] nr14, nr15, etg15, acc16;
  logic [LANES-1:0][15:0]            outc;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      outc[i] = c16.ok ? sat16(rnd_shr(64'(signed'(acc16[i])), OUT_SH)) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;  v2 <= 1'b0;  v3 <= 1'b0;  v4 <= 1'b0;
      v5 <= 1'b0;  v6 <= 1'b0;  v7 <= 1'b0;  v8 <= 1'b0;
      v9 <= 1'b0;  v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
      v13 <= 1'b0; v14 <= 1'b0; v15 <= 1'b0; v16 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= accept;  v2 <= v1;   v3 <= v3a;  v4 <= v4a;
      v5 <= v4;      v6 <= v5;   v7 <= v6;   v8 <= v7;
      v9 <= v8;      v10 <= v9;  v11 <= v10; v12 <= v11;
      v13 <= v13a;   v14 <= v13; v15 <= v14; v16 <= v15;
      done <= v16;
    end
  end

  always_ff @(posedge clk) begin
    sq1     <= sqc;
    c1.d    <= din;
    c1.n    <= nin;
    c1.eta  <= ray.eta_ratio;
    c1.zero <= 1'b0;

    x2 <= {l2sum, {(SQ1_IW - 32){1'b0}}};
    c2 <= c2n;

    num3 <= num3n;
    den3 <= den3n;
    c3   <= c3a;

    p4 <= p4c;
    c4 <= c4n;

    dot5 <= 34'(signed'(p4[0])) + 34'(signed'(p4[1])) + 34'(signed'(p4[2]));
    c5   <= c4;
    c6   <= c6n;
    dsq7 <= OM_W'(signed'(c6.dt)) * OM_W'(signed'(c6.dt));
    c7   <= c6;
    om8  <= OM_W'(ONE_Q28) - dsq7;
    c8   <= c7;
    eo9  <= EO_W'(om8) * EO_W'(c8.eta);
    c9   <= c8;
    t10  <= T_W'(rnd_shr(64'(eo9), Q_SH));
    c10  <= c9;
    et11 <= ET_W'(t10) * ET_W'(c10.eta);
    c11  <= c10;
    d12  <= discc[SQ2_IW-1:0];
    c12  <= c12n;

    for (int i = 0; i < LANES; i++) begin
      nd13[i]   <= ND_W'(signed'(c13a.n[i])) * ND_W'(signed'(c13a.dt));
      nr13[i]   <= NR_W'(signed'(c13a.n[i])) * NR_W'(root13);
      tang14[i] <= (TG_W'(signed'(c13.u[i])) <<< Q_SH) - TG_W'(signed'(nd13[i]));
      nr14[i]   <= AC_W'(signed'(nr13[i])) <<< ROOT_SH;
      etg15[i]  <= AC_W'(signed'(tang14[i])) * AC_W'(c14.eta);
      nr15[i]   <= nr14[i];
      acc16[i]  <= etg15[i] - nr15[i];
    end
    c13 <= c13a;
    c14 <= c13;
    c15 <= c14;
    c16 <= c15;

    result.out_x       <= outc[0];
    result.out_y       <= outc[1];
    result.out_z       <= outc[2];
    result.did_refract <= c16.ok;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted request produced no result at the expected cycle");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching request");

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    done && !result.did_refract |->
      result.out_x == 16'sd0 && result.out_y == 16'sd0 && result.out_z == 16'sd0)
    else $error("non-refracted result carries a nonzero vector");

endmodule

`default_nettype wire

[sim/tb_vector_refraction.sv]
module tb_vector_refraction;
  timeunit 1ns;
  timeprecision 1ps;
  import vr_pkg::*;

  localparam int LATENCY = 90;

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic vr_res_t refract_ray(input vr_ray_t r);
    vr_res_t o;
    longint d[3];
    longint n[3];
    longint u[3];
    longint eta, dot, dt, om, t, disc, root, tang, acc, q;
    longint unsigned l2, s, m;
    d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
    n[0] = r.norm_x; n[1] = r.norm_y; n[2] = r.norm_z;
    eta = longint'({48'd0, r.eta_ratio});
    o = '0;
    l2 = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) l2 += d[i] * d[i];
    if (l2 == 0) return o;
    s = floor_root(l2 << 28);
    for (int i = 0; i < 3; i++) begin
      m = ((d[i] < 0) ? -d[i] : d[i]) << 29;
      q = (m + s) / (2 * s);
      u[i] = (d[i] < 0) ? -q : q;
      dot += u[i] * n[i];
    end
    dt = round_shift(dot, 14);
    om = (64'sd1 << 28) - dt * dt;
    t = round_shift(eta * om, 14);
    disc = (64'sd1 << 42) - eta * t;
    if (disc <= 0) return o;
    root = floor_root(disc);
    for (int i = 0; i < 3; i++) begin
      tang = u[i] * 16384 - n[i] * dt;
      acc = eta * tang - n[i] * root * 128;
      q = round_shift(acc, 28);
      if (i == 0) o.out_x = clamp16(q);
      else if (i == 1) o.out_y = clamp16(q);
      else o.out_z = clamp16(q);
    end
    o.did_refract = 1'b1;
    return o;
  endfunction

  class refraction_scoreboard;
    vr_res_t pending[$];
    int errors;

    function void note_request(vr_ray_t r);
      pending.push_back(refract_ray(r));
    endfunction

    function void check_result(vr_res_t got);
      vr_res_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.out_x !== exp_r.out_x) begin
        $error("out_x expected %0d got %0d", exp_r.out_x, got.out_x); errors++;
      end
      if (got.out_y !== exp_r.out_y) begin
        $error("out_y expected %0d got %0d", exp_r.out_y, got.out_y); errors++;
      end
      if (got.out_z !== exp_r.out_z) begin
        $error("out_z expected %0d got %0d", exp_r.out_z, got.out_z); errors++;
      end
      if (got.did_refract !== exp_r.did_refract) begin
        $error("did_refract expected %0b got %0b", exp_r.did_refract, got.did_refract);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  vr_ray_t ray;
  vr_res_t result;
  refraction_scoreboard board;
  int idle_pct;

  vector_refraction u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ray(ray), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("vector_refraction verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Holds one request on the port until it is taken, with optional idle gaps first.
  task automatic send_ray(input vr_ray_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    ray <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(r);
  endtask

  function automatic logic [15:0] unit_comp(input real v);
    return 16'(int'(v * 16384.0));
  endfunction

  // Random unit normal and random direction; most requests are well formed.
  function automatic vr_ray_t random_ray();
    vr_ray_t r;
    real a, b, c, len;
    r = vr_ray_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(9) < 8) begin
      a = real'(int'($urandom_range(2000)) - 1000);
      b = real'(int'($urandom_range(2000)) - 1000);
      c = real'(int'($urandom_range(2000)) - 1000);
      len = $sqrt(a * a + b * b + c * c);
      if (len == 0.0) begin
        a = 1.0; len = 1.0;
      end
      r.norm_x = unit_comp(a / len);
      r.norm_y = unit_comp(b / len);
      r.norm_z = unit_comp(c / len);
      r.eta_ratio = 16'($urandom_range(8192, 32768));
      if ($urandom_range(3) == 0) begin
        r.dir_x = 16'(int'($urandom_range(64)) - 32);
        r.dir_y = 16'(int'($urandom_range(64)) - 32);
        r.dir_z = 16'(int'($urandom_range(64)) - 32);
      end
    end
    return r;
  endfunction

  task automatic directed_rays();
    vr_ray_t r;
    r = '0; r.norm_z = 16'sd16384; r.eta_ratio = 16'd16384;
    send_ray(r);                                 // zero direction
    r.dir_z = -16'sd4096; send_ray(r);           // straight through
    r.dir_x = 16'sd4096; r.eta_ratio = 16'd24576; send_ray(r);
    r.dir_z = -16'sd100; r.eta_ratio = 16'hffff; send_ray(r);  // total reflection
    r.eta_ratio = 16'd0; send_ray(r);
    r = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff};
    send_ray(r);
    r = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000};
    send_ray(r);
    r = '{16'h8000, 16'h7fff, 16'h0001, 16'h8000, 16'h7fff, 16'h0000, 16'h0001};
    send_ray(r);
    // Non-unit normal drives the discriminant large and the output to saturation.
    r = '{16'h1000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000};
    send_ray(r);
    r = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000};
    send_ray(r);
    r = '{16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hc000, 16'h2000};
    send_ray(r);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    ray = '0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    directed_rays();
    for (int i = 0; i < 1500; i++) begin
      case ((i / 150) % 4)
        0: idle_pct = 0;
        1: idle_pct = 48;
        2: idle_pct = 13;
        default: idle_pct = 0;
      endcase
      send_ray(random_ray());
    end
    start <= 1'b0;
    for (int w = 0; w < 100000 && board.pending.size() != 0; w++) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("vector_refraction verification clean");
    end else begin
      $display("vector_refraction verification failed");
    end
    $finish;
  end
endmodule
